// ----- rtl/qte_pkg.sv -----
// Shared types, constants and codes of the quintic trajectory evaluator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package qte_pkg;

   // defaults of the top level parameters
   localparam int AXES_DEF  = 3;
   localparam int TERMS_DEF = 6;

   // result ports carry three axes and three derivative orders
   localparam int OUT_AXES   = 3;
   localparam int NUM_DERIVS = 3;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_DURATION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE   = 2'd1;

   // saturation limits
   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
   localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
   localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   // one request as it arrives
   typedef struct packed {
      op_type             op;
      logic [1:0]         axis;
      logic [2:0]         term;
      logic signed [63:0] coefficient;
      logic [31:0]        elapsed_time;
   } req_type;

   // one result
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_z;
      logic               saturated;
   } rsp_type;

   // classified request as queued for the back end (time already clamped)
   typedef struct packed {
      logic               is_eval;
      logic [1:0]         axis;
      logic [2:0]         term;
      logic signed [63:0] coefficient;
      logic [31:0]        t;
   } job_type;

endpackage

`default_nettype wire

// ----- rtl/qte_front.sv -----
// Front end: takes requests, holds the configuration registers, clamps time
// and drops requests that do nothing. Depends on qte_pkg.
`default_nettype none

module qte_front
   import qte_pkg::*;
#(
   parameter int AXES  = AXES_DEF,
   parameter int TERMS = TERMS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire req_type                req_payload,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output logic                        csr_ready,
   input  wire logic                   q_full,
   output logic                        busy,
   output logic                        push,
   output job_type                     job
);

   logic [31:0] duration_ff, duration_in;
   logic        enable_ff, enable_in;
   logic        accept;
   logic        keep;

   assign csr_ready = 1'b1;
   assign busy      = q_full;
   assign accept    = start && !busy;

   // decode register writes; drop writes to unknown indexes
   always_comb begin
      duration_in = duration_ff;
      enable_in   = enable_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DURATION: begin
               duration_in = csr_data;
            end
            CSR_ENABLE: begin
               enable_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= '0;
         enable_ff   <= 1'b0;
      end else begin
         duration_ff <= duration_in;
         enable_ff   <= enable_in;
      end
   end

   // classify: drop disabled evaluations and loads outside the table
   always_comb begin
      if (req_payload.op == OP_EVAL) begin
         keep = enable_ff;
      end else begin
         keep = (int'(req_payload.axis) < AXES) && (int'(req_payload.term) < TERMS);
      end
      job.is_eval     = (req_payload.op == OP_EVAL);
      job.axis        = req_payload.axis;
      job.term        = req_payload.term;
      job.coefficient = req_payload.coefficient;
      job.t           = (req_payload.elapsed_time > duration_ff) ? duration_ff
                                                                 : req_payload.elapsed_time;
   end

   assign push = accept && keep;

endmodule

`default_nettype wire

// ----- rtl/qte_queue.sv -----
// Short queue of classified requests between front and back end.
// Depends on qte_pkg.
`default_nettype none

module qte_queue
   import qte_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         empty,
   output job_type      head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed request
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("queue pushed while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue popped while empty");

   a_count_up : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ----- rtl/qte_back.sv -----
// Back end: Horner pipeline over all axes and derivative orders, with the
// coefficient table written in step with the pipeline. Depends on qte_pkg.
`default_nettype none

module qte_back
   import qte_pkg::*;
#(
   parameter int AXES  = AXES_DEF,
   parameter int TERMS = TERMS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire job_type in_job,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload
);

   localparam int LANE_AX = (AXES < OUT_AXES) ? AXES : OUT_AXES;

   typedef struct packed {
      logic               valid;
      logic               is_eval;
      logic [1:0]         axis;
      logic [2:0]         term;
      logic signed [63:0] coefficient;
      logic [31:0]        t;
      logic               sat;
   } pipe_item_type;

   // scale of coefficient k in the derivative of order d
   function automatic int deriv_scale(input int d, input int k);
      int m;
      begin
         m = 1;
         if (d == 1) m = k;
         else if (d == 2) m = k * (k - 1);
         return m;
      end
   endfunction

   // stage registers: A multiplies, M rescales by time, C adds the coefficient
   pipe_item_type      item_a_ff [TERMS];
   pipe_item_type      item_m_ff [TERMS];
   pipe_item_type      item_c_ff [TERMS];
   logic [63:0]        p0_ff  [TERMS][NUM_DERIVS][LANE_AX];
   logic [63:0]        p1_ff  [TERMS][NUM_DERIVS][LANE_AX];
   logic               neg_ff [TERMS][NUM_DERIVS][LANE_AX];
   logic signed [63:0] cm_ff  [TERMS][NUM_DERIVS][LANE_AX];
   logic signed [63:0] cmm_ff [TERMS][NUM_DERIVS][LANE_AX];
   logic signed [63:0] mt_ff  [TERMS][NUM_DERIVS][LANE_AX];
   logic signed [63:0] acc_ff [TERMS][NUM_DERIVS][LANE_AX];

   for (genvar s = 0; s < TERMS; s++) begin : g_step
      localparam int K = TERMS - 1 - s;

      pipe_item_type      in_item;
      logic signed [63:0] in_acc [NUM_DERIVS][LANE_AX];
      logic signed [63:0] coef_row_ff [LANE_AX];
      pipe_item_type      item_a_in, item_m_in, item_c_in;
      logic [63:0]        p0_in  [NUM_DERIVS][LANE_AX];
      logic [63:0]        p1_in  [NUM_DERIVS][LANE_AX];
      logic               neg_in [NUM_DERIVS][LANE_AX];
      logic signed [63:0] cm_in  [NUM_DERIVS][LANE_AX];
      logic signed [63:0] mt_in  [NUM_DERIVS][LANE_AX];
      logic signed [63:0] acc_in [NUM_DERIVS][LANE_AX];

      // select the step input: a fresh request or the previous step
      if (s == 0) begin : g_head
         always_comb begin
            in_item.valid       = in_valid;
            in_item.is_eval     = in_job.is_eval;
            in_item.axis        = in_job.axis;
            in_item.term        = in_job.term;
            in_item.coefficient = in_job.coefficient;
            in_item.t           = in_job.t;
            in_item.sat         = 1'b0;
            for (int d = 0; d < NUM_DERIVS; d++) begin
               for (int a = 0; a < LANE_AX; a++) begin
                  in_acc[d][a] = '0;
               end
            end
         end
      end else begin : g_link
         always_comb begin
            in_item = item_c_ff[s-1];
            for (int d = 0; d < NUM_DERIVS; d++) begin
               for (int a = 0; a < LANE_AX; a++) begin
                  in_acc[d][a] = acc_ff[s-1][d][a];
               end
            end
         end
      end

      // write this step's table row as a load passes, so order is kept
      always_ff @(posedge clock) begin
         if (reset) begin
            for (int a = 0; a < LANE_AX; a++) begin
               coef_row_ff[a] <= '0;
            end
         end else if (in_item.valid && !in_item.is_eval && in_item.term == 3'(K)) begin
            for (int a = 0; a < LANE_AX; a++) begin
               if (in_item.axis == 2'(a)) begin
                  coef_row_ff[a] <= in_item.coefficient;
               end
            end
         end
      end

      // stage A: split magnitude times time, scale the coefficient
      always_comb begin
         logic [63:0]        mag;
         logic signed [70:0] prod;
         logic               ovf;
         item_a_in = in_item;
         for (int d = 0; d < NUM_DERIVS; d++) begin
            for (int a = 0; a < LANE_AX; a++) begin
               mag  = in_acc[d][a][63] ? 64'(-in_acc[d][a]) : 64'(in_acc[d][a]);
               prod = 71'(coef_row_ff[a]) * 71'(signed'({1'b0, 6'(deriv_scale(d, K))}));
               ovf  = !((&prod[70:63]) || !(|prod[70:63]));
               if (K >= d) begin
                  p0_in[d][a]  = 64'(mag[31:0]) * 64'(in_item.t);
                  p1_in[d][a]  = 64'(mag[63:32]) * 64'(in_item.t);
                  neg_in[d][a] = in_acc[d][a][63];
                  cm_in[d][a]  = ovf ? (prod[70] ? S64_MIN : S64_MAX) : prod[63:0];
                  item_a_in.sat = item_a_in.sat | ovf;
               end else begin
                  // beyond this order: carry the finished sum through
                  p0_in[d][a]  = '0;
                  p1_in[d][a]  = '0;
                  neg_in[d][a] = 1'b0;
                  cm_in[d][a]  = in_acc[d][a];
               end
            end
         end
      end

      // stage M: floor(acc * t / 2^16) with saturation
      always_comb begin
         logic [95:0] full;
         logic [80:0] q;
         logic        rnd;
         item_m_in = item_a_ff[s];
         for (int d = 0; d < NUM_DERIVS; d++) begin
            for (int a = 0; a < LANE_AX; a++) begin
               full = {32'b0, p0_ff[s][d][a]} + {p1_ff[s][d][a], 32'b0};
               rnd  = neg_ff[s][d][a] && (p0_ff[s][d][a][15:0] != '0);
               q    = {1'b0, full[95:16]} + 81'(rnd);
               if (!neg_ff[s][d][a]) begin
                  if (q > {17'b0, S64_MAX}) begin
                     mt_in[d][a] = S64_MAX;
                     item_m_in.sat = 1'b1;
                  end else begin
                     mt_in[d][a] = q[63:0];
                  end
               end else begin
                  if (q > {17'b0, S64_MIN}) begin
                     mt_in[d][a] = S64_MIN;
                     item_m_in.sat = 1'b1;
                  end else begin
                     mt_in[d][a] = -q[63:0];
                  end
               end
            end
         end
      end

      // stage C: add the scaled coefficient with saturation
      always_comb begin
         logic [64:0] sum;
         item_c_in = item_m_ff[s];
         for (int d = 0; d < NUM_DERIVS; d++) begin
            for (int a = 0; a < LANE_AX; a++) begin
               sum = {mt_ff[s][d][a][63], mt_ff[s][d][a]}
                   + {cmm_ff[s][d][a][63], cmm_ff[s][d][a]};
               if (sum[64] != sum[63]) begin
                  acc_in[d][a] = sum[64] ? S64_MIN : S64_MAX;
                  item_c_in.sat = 1'b1;
               end else begin
                  acc_in[d][a] = sum[63:0];
               end
            end
         end
      end

      // hold valid bits under reset, payload free-running
      always_ff @(posedge clock) begin
         if (reset) begin
            item_a_ff[s].valid <= 1'b0;
            item_m_ff[s].valid <= 1'b0;
            item_c_ff[s].valid <= 1'b0;
         end else begin
            item_a_ff[s].valid <= item_a_in.valid;
            item_m_ff[s].valid <= item_m_in.valid;
            item_c_ff[s].valid <= item_c_in.valid;
         end
         item_a_ff[s].is_eval     <= item_a_in.is_eval;
         item_a_ff[s].axis        <= item_a_in.axis;
         item_a_ff[s].term        <= item_a_in.term;
         item_a_ff[s].coefficient <= item_a_in.coefficient;
         item_a_ff[s].t           <= item_a_in.t;
         item_a_ff[s].sat         <= item_a_in.sat;
         item_m_ff[s].is_eval     <= item_m_in.is_eval;
         item_m_ff[s].axis        <= item_m_in.axis;
         item_m_ff[s].term        <= item_m_in.term;
         item_m_ff[s].coefficient <= item_m_in.coefficient;
         item_m_ff[s].t           <= item_m_in.t;
         item_m_ff[s].sat         <= item_m_in.sat;
         item_c_ff[s].is_eval     <= item_c_in.is_eval;
         item_c_ff[s].axis        <= item_c_in.axis;
         item_c_ff[s].term        <= item_c_in.term;
         item_c_ff[s].coefficient <= item_c_in.coefficient;
         item_c_ff[s].t           <= item_c_in.t;
         item_c_ff[s].sat         <= item_c_in.sat;
         for (int d = 0; d < NUM_DERIVS; d++) begin
            for (int a = 0; a < LANE_AX; a++) begin
               p0_ff[s][d][a]  <= p0_in[d][a];
               p1_ff[s][d][a]  <= p1_in[d][a];
               neg_ff[s][d][a] <= neg_in[d][a];
               cm_ff[s][d][a]  <= cm_in[d][a];
               cmm_ff[s][d][a] <= cm_ff[s][d][a];
               mt_ff[s][d][a]  <= mt_in[d][a];
               acc_ff[s][d][a] <= acc_in[d][a];
            end
         end
      end
   end

   // reduce to Q16.16 and drive the result register
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;
   logic signed [31:0] res [NUM_DERIVS][OUT_AXES];

   always_comb begin
      logic [47:0]   r;
      logic          any_sat;
      pipe_item_type last;
      last    = item_c_ff[TERMS-1];
      any_sat = last.sat;
      for (int d = 0; d < NUM_DERIVS; d++) begin
         for (int a = 0; a < OUT_AXES; a++) begin
            res[d][a] = '0;
         end
         for (int a = 0; a < LANE_AX; a++) begin
            r = acc_ff[TERMS-1][d][a][63:16];
            if (!((&r[47:31]) || !(|r[47:31]))) begin
               res[d][a] = r[47] ? S32_MIN : S32_MAX;
               any_sat   = 1'b1;
            end else begin
               res[d][a] = r[31:0];
            end
         end
      end
      rsp_strobe_in       = last.valid && last.is_eval;
      rsp_in.pos_x        = res[0][0];
      rsp_in.pos_y        = res[0][1];
      rsp_in.pos_z        = res[0][2];
      rsp_in.vel_x        = res[1][0];
      rsp_in.vel_y        = res[1][1];
      rsp_in.vel_z        = res[1][2];
      rsp_in.acc_x        = res[2][0];
      rsp_in.acc_y        = res[2][1];
      rsp_in.acc_z        = res[2][2];
      rsp_in.saturated    = any_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_load_silent : assert property (@(posedge clock) disable iff (reset)
      (item_c_ff[TERMS-1].valid && !item_c_ff[TERMS-1].is_eval) |=> !rsp_strobe)
      else $error("load request produced a result");

   a_eval_answers : assert property (@(posedge clock) disable iff (reset)
      (item_c_ff[TERMS-1].valid && item_c_ff[TERMS-1].is_eval) |=> rsp_strobe)
      else $error("evaluation lost at the output");

   a_strobe_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(item_c_ff[TERMS-1].valid))
      else $error("result strobe without a finished evaluation");

endmodule

`default_nettype wire

// ----- rtl/quintic_trajectory_evaluator_top.sv -----
// Top level of the quintic trajectory evaluator: front end, request queue and
// Horner back end. Depends on qte_pkg, qte_front, qte_queue and qte_back.
//
//  channel   ports                                   flow
//  request   start, busy, req_payload                in, taken on start & !busy
//  result    rsp_strobe, rsp_payload                 out, one cycle per result
//  config    csr_valid, csr_ready, csr_index, csr_data  in, taken on valid & ready
//
// One request is taken per cycle while busy is low. An evaluation passes
// through the queue register, three pipeline stages per Horner step
// (multiply, rescale, add) and the output register before its result
// returns. Loads ride the same pipeline and write their table row at the
// step that reads it. Reset clears the configuration, the table and all
// valid bits. The receiver cannot stall.
`default_nettype none

module quintic_trajectory_evaluator_top
   import qte_pkg::*;
#(
   parameter int AXES  = AXES_DEF,
   parameter int TERMS = TERMS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_payload,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic    push;
   job_type push_job;
   logic    q_full;
   logic    q_empty;
   job_type q_head;

   qte_front #(
      .AXES  (AXES),
      .TERMS (TERMS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .csr_ready   (csr_ready),
      .q_full      (q_full),
      .busy        (busy),
      .push        (push),
      .job         (push_job)
   );

   qte_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (!q_empty),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   qte_back #(
      .AXES  (AXES),
      .TERMS (TERMS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (!q_empty),
      .in_job      (q_head),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
